/* hw/rtl/slha_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slha_pkg
// Shared types and constants of the status LED HSV animator.
// ----------------------------------------------------------------------------
package slha_pkg;

  localparam int unsigned ERROR_PEAK_LEVEL_DEF = 255;
  localparam int unsigned CFG_AW = 5;

  localparam logic [2:0] REG_MIN_INTERVAL = 3'd0;
  localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_HUE_STEP     = 3'd2;
  localparam logic [2:0] REG_ACTIVE_LEVEL = 3'd3;
  localparam logic [2:0] REG_IDLE_FLOOR   = 3'd4;
  localparam logic [2:0] REG_IDLE_PERIOD  = 3'd5;
  localparam logic [2:0] REG_ERROR_PERIOD = 3'd6;
  localparam logic [2:0] REG_ERROR_FLOOR  = 3'd7;

  localparam logic [1:0] MODE_ACTIVE = 2'd0;
  localparam logic [1:0] MODE_IDLE   = 2'd1;
  localparam logic [1:0] MODE_ERROR  = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [31:0] now_time;
    logic        relaying;
  } in_item_t;

  typedef struct packed {
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
    logic [1:0] mode_code;
  } out_item_t;

endpackage
`default_nettype wire

/* hw/rtl/slha_divu.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slha_divu
// Restoring radix-2 divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slha_divu #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quot,
  output logic [W-1:0]      rem
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt, r_r, r_nxt, d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0]    trial;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {r_r, q_r[W-1]};
    if (start) begin
      q_nxt = dividend; r_nxt = '0; cnt_nxt = CW'(W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = W'(trial - {1'b0, d_r});
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt;
    if (start) d_r <= divisor;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule
`default_nettype wire

/* hw/rtl/status_led_hsv_animator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Flow: a report or a tick without a frame ends after the decide step;
// an active-mode frame skips the wave and a flat wave skips its divides;
// a breathing wave runs two 32-bit serial divides for the wave (now mod
// period, level quotient); every frame runs two for the HSV /255 products.
// Throughput: one transaction at a time; a waiting frame holds only the
// final step. Reset: synchronous, clears hue and times, config to defaults.
// ----------------------------------------------------------------------------
// status_led_hsv_animator
// Picks the LED mode, computes the breathing level and converts HSV to GRB.
// ----------------------------------------------------------------------------
module status_led_hsv_animator #(
  parameter int unsigned ERROR_PEAK_LEVEL = slha_pkg::ERROR_PEAK_LEVEL_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire slha_pkg::in_item_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output slha_pkg::out_item_t             out_data,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [slha_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_MOD, S_MODW, S_LVL, S_LVLW, S_HSV, S_P,
    S_PW, S_P2, S_P2W, S_DONE
  } state_t;

  state_t      state_r;
  logic [15:0] min_int_r, idle_to_r, idle_per_r, err_per_r;
  logic [7:0]  hue_step_r, act_lvl_r, idle_fl_r, err_fl_r;
  logic [7:0]  hue_acc_r, last_hue_r;
  logic [31:0] last_emit_r, last_rep_r;
  logic        started_r;
  slha_pkg::in_item_t  item_r;
  slha_pkg::out_item_t res_r;
  logic        res_v_r;
  logic [1:0]  mode_r;
  logic [7:0]  hue_r, lvl_r, lo_r, hi_r, rem_r;
  logic [15:0] period_r, up_r;
  logic [7:0]  qv_r, tv_r;

  logic        dv_start, dv_done;
  logic [31:0] dv_a, dv_b, dv_q, dv_rm;

  slha_divu #(.W(32)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .quot(dv_q), .rem(dv_rm)
  );

  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    unique case (cfg_idx)
      slha_pkg::REG_MIN_INTERVAL: prdata = {16'd0, min_int_r};
      slha_pkg::REG_IDLE_TIMEOUT: prdata = {16'd0, idle_to_r};
      slha_pkg::REG_HUE_STEP:     prdata = {24'd0, hue_step_r};
      slha_pkg::REG_ACTIVE_LEVEL: prdata = {24'd0, act_lvl_r};
      slha_pkg::REG_IDLE_FLOOR:   prdata = {24'd0, idle_fl_r};
      slha_pkg::REG_IDLE_PERIOD:  prdata = {16'd0, idle_per_r};
      slha_pkg::REG_ERROR_PERIOD: prdata = {16'd0, err_per_r};
      default:                    prdata = {24'd0, err_fl_r};
    endcase
  end

  logic res_free, res_load;
  assign res_free  = !res_v_r || !out_stall;
  assign res_load  = (state_r == S_DONE) && res_free;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = res_v_r;
  assign out_data  = res_r;

  logic [31:0] d_rep, d_emit;
  logic [1:0]  mode_c;
  logic        want_c;
  assign d_rep  = item_r.now_time - last_rep_r;
  assign d_emit = item_r.now_time - last_emit_r;
  always_comb begin
    if (!item_r.relaying) mode_c = slha_pkg::MODE_ERROR;
    else if (d_rep >= {16'd0, idle_to_r}) mode_c = slha_pkg::MODE_IDLE;
    else mode_c = slha_pkg::MODE_ACTIVE;
    if (mode_c == slha_pkg::MODE_ACTIVE)
      want_c = !started_r || (hue_acc_r != last_hue_r && d_emit >= {16'd0, min_int_r});
    else
      want_c = !started_r || (d_emit >= {16'd0, min_int_r});
  end

  // wave and hsv helpers
  logic [15:0] half_c, ph_c, up_c;
  logic [7:0]  diff_c;
  logic [23:0] prod_c;
  logic [10:0] h6_c;
  logic [2:0]  region_c;
  logic [7:0]  rem_c, lo_eff;
  assign half_c = {1'b0, period_r[15:1]};
  assign ph_c   = dv_rm[15:0];
  always_comb begin
    up_c = (ph_c < half_c) ? ph_c : (period_r - ph_c);
    if (up_c > half_c) up_c = half_c;
  end
  assign lo_eff = (lo_r > hi_r) ? hi_r : lo_r;
  assign diff_c = hi_r - lo_eff;
  assign prod_c = {16'd0, diff_c} * {8'd0, up_r};
  assign h6_c   = 11'(hue_r) * 11'd6;
  always_comb begin
    if (h6_c >= 11'd1530) begin region_c = 3'd5; rem_c = 8'd255; end
    else if (h6_c >= 11'd1275) begin region_c = 3'd5; rem_c = 8'(h6_c - 11'd1275); end
    else if (h6_c >= 11'd1020) begin region_c = 3'd4; rem_c = 8'(h6_c - 11'd1020); end
    else if (h6_c >= 11'd765) begin region_c = 3'd3; rem_c = 8'(h6_c - 11'd765); end
    else if (h6_c >= 11'd510) begin region_c = 3'd2; rem_c = 8'(h6_c - 11'd510); end
    else if (h6_c >= 11'd255) begin region_c = 3'd1; rem_c = 8'(h6_c - 11'd255); end
    else begin region_c = 3'd0; rem_c = 8'(h6_c); end
  end

  logic [2:0] region_r;

  always_comb begin
    dv_start = 1'b0; dv_a = '0; dv_b = 32'd1;
    unique case (state_r)
      S_MOD: begin dv_start = 1'b1; dv_a = item_r.now_time; dv_b = {16'd0, period_r}; end
      S_LVL: begin dv_start = 1'b1; dv_a = {8'd0, prod_c}; dv_b = {16'd0, half_c}; end
      S_P:  begin dv_start = 1'b1; dv_a = 32'(lvl_r) * 32'(8'd255 - rem_r); dv_b = 32'd255; end
      S_P2: begin dv_start = 1'b1; dv_a = 32'(lvl_r) * 32'(rem_r); dv_b = 32'd255; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; res_v_r <= 1'b0;
      min_int_r <= 16'd16; idle_to_r <= 16'd2000; hue_step_r <= 8'd1;
      act_lvl_r <= 8'd64; idle_fl_r <= 8'd8; idle_per_r <= 16'd3000;
      err_per_r <= 16'd1000; err_fl_r <= 8'd8;
      hue_acc_r <= '0; last_hue_r <= '0; last_emit_r <= '0; last_rep_r <= '0;
      started_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          slha_pkg::REG_MIN_INTERVAL: min_int_r  <= pwdata[15:0];
          slha_pkg::REG_IDLE_TIMEOUT: idle_to_r  <= pwdata[15:0];
          slha_pkg::REG_HUE_STEP:     hue_step_r <= pwdata[7:0];
          slha_pkg::REG_ACTIVE_LEVEL: act_lvl_r  <= pwdata[7:0];
          slha_pkg::REG_IDLE_FLOOR:   idle_fl_r  <= pwdata[7:0];
          slha_pkg::REG_IDLE_PERIOD:  idle_per_r <= pwdata[15:0];
          slha_pkg::REG_ERROR_PERIOD: err_per_r  <= pwdata[15:0];
          default:                    err_fl_r   <= pwdata[7:0];
        endcase
      end
      if (res_load) res_v_r <= 1'b1;
      else if (!out_stall) res_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          item_r <= in_data; state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (item_r.kind) begin
            hue_acc_r <= hue_acc_r + hue_step_r; last_rep_r <= item_r.now_time;
            state_r <= S_IDLE;
          end else if (!want_c) begin
            state_r <= S_IDLE;
          end else begin
            mode_r <= mode_c;
            last_emit_r <= item_r.now_time; started_r <= 1'b1;
            if (mode_c == slha_pkg::MODE_ERROR) begin
              hue_r <= '0; lo_r <= err_fl_r; hi_r <= 8'(ERROR_PEAK_LEVEL);
              period_r <= err_per_r;
            end else begin
              hue_r <= hue_acc_r; lo_r <= idle_fl_r; hi_r <= act_lvl_r;
              period_r <= idle_per_r;
            end
            if (mode_c == slha_pkg::MODE_ACTIVE) begin
              last_hue_r <= hue_acc_r; lvl_r <= act_lvl_r; state_r <= S_HSV;
            end else begin
              state_r <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (period_r[15:1] == 15'd0) begin lvl_r <= hi_r; state_r <= S_HSV; end
          else state_r <= S_MODW;
        end
        S_MODW: if (dv_done) begin
          up_r <= up_c; state_r <= S_LVL;
        end
        S_LVL: state_r <= S_LVLW;
        S_LVLW: if (dv_done) begin
          lvl_r <= lo_eff + dv_q[7:0]; state_r <= S_HSV;
        end
        S_HSV: begin
          region_r <= region_c; rem_r <= rem_c; state_r <= S_P;
        end
        S_P: state_r <= S_PW;
        S_PW: if (dv_done) begin
          // t = v*(255-(255-rem))/255 ... with s=255: t=v*rem/255, q=v*(255-rem)/255
          qv_r <= dv_q[7:0]; state_r <= S_P2;
        end
        S_P2: state_r <= S_P2W;
        S_P2W: if (dv_done) begin
          tv_r <= dv_q[7:0]; state_r <= S_DONE;
        end
        S_DONE: if (res_free) begin
          unique case (region_r)
            3'd0: begin res_r.red <= lvl_r; res_r.green <= tv_r; res_r.blue <= 8'd0; end
            3'd1: begin res_r.red <= qv_r; res_r.green <= lvl_r; res_r.blue <= 8'd0; end
            3'd2: begin res_r.red <= 8'd0; res_r.green <= lvl_r; res_r.blue <= tv_r; end
            3'd3: begin res_r.red <= 8'd0; res_r.green <= qv_r; res_r.blue <= lvl_r; end
            3'd4: begin res_r.red <= tv_r; res_r.green <= 8'd0; res_r.blue <= lvl_r; end
            default: begin res_r.red <= lvl_r; res_r.green <= 8'd0; res_r.blue <= qv_r; end
          endcase
          res_r.mode_code <= mode_r; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  logic unused_ok;
  assign unused_ok = ^{dv_q[31:8], dv_rm[31:16]};

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid && out_stall) |=> state_r == S_DONE)
    else $error("new result loaded over a held one");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("held result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.mode_code != 2'd3)
    else $error("bad mode code");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_DECIDE)
    else $error("accepted transaction not taken");

endmodule
`default_nettype wire
